// ----- design/ozap_pkg.sv -----
// Shared types and constants for the obstacle zone alert policy.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ozap_pkg;

  localparam int unsigned DistW   = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned NumW    = 17;
  localparam int unsigned DivSteps = 17;

  localparam logic [7:0] SideFarRst   = 8'd100;
  localparam logic [7:0] FrontFarRst  = 8'd100;
  localparam logic [7:0] SideMidRst   = 8'd62;
  localparam logic [7:0] SideCloseRst = 8'd30;

  localparam logic [1:0] RegSideFar   = 2'd0;
  localparam logic [1:0] RegFrontFar  = 2'd1;
  localparam logic [1:0] RegSideMid   = 2'd2;
  localparam logic [1:0] RegSideClose = 2'd3;

  localparam logic [2:0] CueNone    = 3'd0;
  localparam logic [2:0] CueAhead   = 3'd1;
  localparam logic [2:0] CueLeftBlk = 3'd2;
  localparam logic [2:0] CueGoLeft  = 3'd3;
  localparam logic [2:0] CueRightBlk = 3'd4;
  localparam logic [2:0] CueGoRight = 3'd5;
  localparam logic [2:0] CueStop    = 3'd6;

  localparam logic [3:0] ZoneNoMatch = 4'd8;

  typedef struct packed {
    logic load;
    logic fstart;
    logic sstart;
    logic step;
    logic fcap;
    logic scap;
    logic finish;
  } ozap_cmd_t;

endpackage
`default_nettype wire

// ----- design/obstacle_zone_alert_policy.sv -----
// Top level of the obstacle zone alert policy: controller plus datapath.
// Depends on ozap_pkg, ozap_ctrl, ozap_dp.
//
// channel | handshake             | payload
// in      | in_valid / in_ready   | dist_left, dist_front, dist_right, headphone_in, now_ms
// out     | out_valid / out_ready | zone, motor_duty, tone_hz, tone_on_ms, tone_off_ms,
//         |                       | cue, cue_play
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each reading goes from transfer to out_valid via two 17-step serial
// divisions (front map, side map) through one shared divider, plus sequencing.
// One reading is in flight at a time; in_ready returns the cycle after the result
// transfer; out_ready low holds the result.
// Reset is synchronous, active low; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module obstacle_zone_alert_policy
  import ozap_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_dist_left,
  input  wire logic [7:0]  in_dist_front,
  input  wire logic [7:0]  in_dist_right,
  input  wire logic        in_headphone_in,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_zone,
  output logic [8:0]       out_motor_duty,
  output logic [11:0]      out_tone_hz,
  output logic [9:0]       out_tone_on_ms,
  output logic [9:0]       out_tone_off_ms,
  output logic [2:0]       out_cue,
  output logic             out_cue_play,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  ozap_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ozap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ozap_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_dist_left    (in_dist_left),
    .in_dist_front   (in_dist_front),
    .in_dist_right   (in_dist_right),
    .in_headphone_in (in_headphone_in),
    .in_now_ms       (in_now_ms),
    .out_zone        (out_zone),
    .out_motor_duty  (out_motor_duty),
    .out_tone_hz     (out_tone_hz),
    .out_tone_on_ms  (out_tone_on_ms),
    .out_tone_off_ms (out_tone_off_ms),
    .out_cue         (out_cue),
    .out_cue_play    (out_cue_play)
  );

endmodule
`default_nettype wire

// ----- design/ozap_ctrl.sv -----
// Controller: sequences load, two serial divisions, result and output transfer.
// Depends on ozap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ozap_ctrl
  import ozap_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ozap_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FINIT, ST_FRUN, ST_SINIT, ST_SRUN, ST_SCAP, ST_FIN, ST_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FINIT;
        end
      end
      ST_FINIT: begin
        cmd.fstart = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_FRUN;
      end
      ST_FRUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'(DivSteps - 1)) state_nxt = ST_SINIT;
      end
      ST_SINIT: begin
        cmd.fcap   = 1'b1;
        cmd.sstart = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_SRUN;
      end
      ST_SRUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'(DivSteps - 1)) state_nxt = ST_SCAP;
      end
      ST_SCAP: begin
        cmd.scap  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/ozap_dp.sv -----
// Datapath: config and history registers, serial divider, result registers.
// Depends on ozap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ozap_dp
  import ozap_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ozap_cmd_t   cmd,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic [7:0]  in_dist_left,
  input  wire logic [7:0]  in_dist_front,
  input  wire logic [7:0]  in_dist_right,
  input  wire logic        in_headphone_in,
  input  wire logic [31:0] in_now_ms,
  output logic [3:0]       out_zone,
  output logic [8:0]       out_motor_duty,
  output logic [11:0]      out_tone_hz,
  output logic [9:0]       out_tone_on_ms,
  output logic [9:0]       out_tone_off_ms,
  output logic [2:0]       out_cue,
  output logic             out_cue_play
);

  logic [7:0]  side_far_r, front_far_r, side_mid_r, side_close_r;
  logic [7:0]  dl_r, df_r, dr_r;
  logic        hp_r;
  logic [31:0] now_r;
  logic [31:0] last_beep_r, last_cue_time_r;
  logic [2:0]  last_cue_r;
  logic [NumW-1:0] num_r;
  logic [8:0]  rem_r;
  logic [7:0]  den_r;
  logic [8:0]  fduty_r, sdur_r;

  logic [3:0]  zone_r;
  logic [2:0]  cue_r;
  logic [8:0]  duty_r;
  logic [11:0] hz_r;
  logic [9:0]  on_r, off_r;
  logic        play_r;

  // zone and side selection
  logic        eq_hit, both_close;
  logic [2:0]  zbits;
  logic [7:0]  sd;
  always_comb begin
    eq_hit = (dl_r == side_far_r) || (df_r == front_far_r) || (dr_r == side_far_r);
    zbits  = {dl_r < side_far_r, df_r < front_far_r, dr_r < side_far_r};
    both_close = (dr_r < side_close_r) && (dl_r < side_close_r);
    case (zbits)
      3'd4, 3'd6: sd = dl_r;
      3'd5, 3'd7: sd = (dr_r < dl_r) ? dr_r : dl_r;
      default:    sd = dr_r;
    endcase
  end

  logic [NumW-1:0] fnum, snum;
  logic [7:0]      fden, sden;
  logic [9:0]      rem_sh;
  logic            ge;
  always_comb begin
    fnum = (df_r > 8'd14) ? NumW'(NumW'(df_r - 8'd14) * NumW'(200)) : '0;
    snum = (sd > 8'd5) ? NumW'(NumW'(sd - 8'd5) * NumW'(450)) : '0;
    fden = (front_far_r > 8'd14) ? front_far_r - 8'd14 : 8'd1;
    sden = (side_far_r > 8'd5) ? side_far_r - 8'd5 : 8'd1;
    rem_sh = {rem_r, num_r[NumW-1]};
    ge     = rem_sh >= {2'b0, den_r};
  end

  // result selection
  logic [3:0]  z_n;
  logic [8:0]  duty_n;
  logic [11:0] hz_n;
  logic [9:0]  on_n, off_n, rt_on, rt_off, lt_on, lt_off;
  logic [2:0]  cue_n;
  logic        spk, play_n, beep_ok, beep_n, rside;
  logic [12:0] hold;
  logic [31:0] cdt, bdt;
  always_comb begin
    z_n = {1'b0, zbits};
    duty_n = '0; hz_n = '0; on_n = '0; off_n = '0;
    cue_n = CueNone; spk = 1'b0; hold = 13'd1500; beep_n = 1'b0;
    rt_on  = {sdur_r, 1'b0};
    rt_off = {2'b0, sdur_r[8:1]};
    lt_on  = rt_off;
    lt_off = rt_on;
    rside  = dr_r < dl_r;
    bdt = now_r - last_beep_r;
    cdt = now_r - last_cue_time_r;
    beep_ok = bdt > 32'd1500;
    if (eq_hit) begin
      z_n = ZoneNoMatch;
    end else begin
      case (zbits)
        3'd0: begin
          if (hp_r) begin spk = 1'b1; cue_n = CueAhead; hold = 13'd5000; end
        end
        3'd1: begin
          if (!hp_r) begin
            hz_n = 12'd528; on_n = rt_on; off_n = rt_off;
          end else if (dr_r > side_mid_r) begin
            spk = 1'b1; cue_n = CueAhead; hold = 13'd5000;
          end else begin
            spk = 1'b1; cue_n = CueRightBlk;
          end
        end
        3'd2: begin
          duty_n = fduty_r;
          if (!hp_r) begin
            if (beep_ok) begin
              hz_n = 12'd1320; on_n = 10'd100; beep_n = 1'b1;
            end
          end else begin
            spk = 1'b1; cue_n = CueStop;
          end
        end
        3'd3: begin
          duty_n = fduty_r;
          if (!hp_r) begin
            hz_n = 12'd792; on_n = rt_on; off_n = rt_off;
          end else if (dr_r > side_mid_r) begin
            spk = 1'b1; cue_n = CueRightBlk;
          end else begin
            spk = 1'b1; cue_n = CueGoLeft;
          end
        end
        3'd4: begin
          if (!hp_r) begin
            hz_n = 12'd1320; on_n = lt_on; off_n = lt_off;
          end else if (dl_r > side_mid_r) begin
            spk = 1'b1; cue_n = CueAhead; hold = 13'd5000;
          end else begin
            spk = 1'b1; cue_n = CueLeftBlk;
          end
        end
        3'd5: begin
          if (!hp_r) begin
            if (both_close) begin
              hz_n = 12'd1848; on_n = 10'd100;
            end else if (rside) begin
              hz_n = 12'd528; on_n = rt_on; off_n = rt_off;
            end else begin
              hz_n = 12'd1320; on_n = lt_on; off_n = lt_off;
            end
          end else begin
            if (both_close) begin hz_n = 12'd1848; on_n = 10'd100; end
            spk = 1'b1;
            if (dr_r > side_mid_r && dl_r > side_mid_r) begin
              cue_n = CueAhead; hold = 13'd5000;
            end else if (dr_r > side_close_r) begin
              cue_n = CueLeftBlk;
            end else if (dl_r > side_close_r) begin
              cue_n = CueRightBlk;
            end else begin
              cue_n = CueStop; hold = 13'd1000;
            end
          end
        end
        3'd6: begin
          duty_n = fduty_r;
          if (!hp_r) begin
            hz_n = 12'd1584; on_n = lt_on; off_n = lt_off;
          end else if (dl_r > side_mid_r) begin
            spk = 1'b1; cue_n = CueLeftBlk;
          end else begin
            spk = 1'b1; cue_n = CueGoRight;
          end
        end
        default: begin
          duty_n = 9'd500;
          if (!hp_r || both_close) begin
            duty_n = fduty_r;
            if (both_close) begin
              hz_n = 12'd2112; on_n = 10'd100;
            end else if (rside) begin
              hz_n = 12'd792; on_n = rt_on; off_n = rt_off;
            end else begin
              hz_n = 12'd1584; on_n = lt_on; off_n = lt_off;
            end
          end
          if (hp_r) begin spk = 1'b1; cue_n = CueStop; hold = 13'd1000; end
        end
      endcase
    end
    play_n = spk && ((cdt > {19'b0, hold}) || (cue_n != last_cue_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_far_r      <= SideFarRst;
      front_far_r     <= FrontFarRst;
      side_mid_r      <= SideMidRst;
      side_close_r    <= SideCloseRst;
      last_beep_r     <= '0;
      last_cue_time_r <= '0;
      last_cue_r      <= CueNone;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegSideFar:   side_far_r   <= cfg_data;
          RegFrontFar:  front_far_r  <= cfg_data;
          RegSideMid:   side_mid_r   <= cfg_data;
          RegSideClose: side_close_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if (beep_n) last_beep_r <= now_r;
        if (spk) begin
          last_cue_time_r <= now_r;
          last_cue_r      <= cue_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dl_r  <= in_dist_left;
      df_r  <= in_dist_front;
      dr_r  <= in_dist_right;
      hp_r  <= in_headphone_in;
      now_r <= in_now_ms;
    end
    if (cmd.fstart) begin
      num_r <= fnum; den_r <= fden; rem_r <= '0;
    end else if (cmd.sstart) begin
      num_r <= snum; den_r <= sden; rem_r <= '0;
    end else if (cmd.step) begin
      rem_r <= ge ? 9'(rem_sh - {2'b0, den_r}) : rem_sh[8:0];
      num_r <= {num_r[NumW-2:0], ge};
    end
    if (cmd.fcap) fduty_r <= (num_r >= NumW'(200)) ? 9'd100 : 9'd300 - num_r[8:0];
    if (cmd.scap) sdur_r  <= (num_r >= NumW'(450)) ? 9'd500 : num_r[8:0] + 9'd50;
    if (cmd.finish) begin
      zone_r <= z_n;
      duty_r <= duty_n;
      hz_r   <= hz_n;
      on_r   <= on_n;
      off_r  <= off_n;
      cue_r  <= cue_n;
      play_r <= play_n;
    end
  end

  assign out_zone        = zone_r;
  assign out_motor_duty  = duty_r;
  assign out_tone_hz     = hz_r;
  assign out_tone_on_ms  = on_r;
  assign out_tone_off_ms = off_r;
  assign out_cue         = cue_r;
  assign out_cue_play    = play_r;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for obstacle_zone_alert_policy: a directed table and
// random readings, predicted by an in-bench zone/tone/cue policy model.
// Depends on ozap_pkg and the obstacle_zone_alert_policy RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import ozap_pkg::*;

  typedef struct packed {
    logic [3:0]  zone;
    logic [8:0]  duty;
    logic [11:0] hz;
    logic [9:0]  on_ms;
    logic [9:0]  off_ms;
    logic [2:0]  cue;
    logic        play;
  } alert_t;

  typedef struct packed {
    logic [7:0]  dl;
    logic [7:0]  df;
    logic [7:0]  dr;
    logic        hp;
    logic [31:0] now;
  } reading_t;

  typedef struct {
    reading_t rd;
    logic     known;
    alert_t   res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_dist_left = '0;
  logic [7:0] in_dist_front = '0;
  logic [7:0] in_dist_right = '0;
  logic in_headphone_in = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_zone;
  logic [8:0] out_motor_duty;
  logic [11:0] out_tone_hz;
  logic [9:0] out_tone_on_ms;
  logic [9:0] out_tone_off_ms;
  logic [2:0] out_cue;
  logic out_cue_play;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  obstacle_zone_alert_policy i_dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [7:0]  p_side_far, p_front_far, p_side_mid, p_side_close;
  logic [31:0] p_last_beep, p_last_cue_time;
  logic [2:0]  p_last_cue;

  alert_t alert_q[$];
  int     fails = 0;
  int     cycles = 0;
  bit     calm = 1'b0;
  bit     hold_long = 1'b0;
  localparam int CycleLimit = 900000;

  function automatic int side_dur(logic [7:0] d);
    int den, v;
    den = (p_side_far > 5) ? int'(p_side_far) - 5 : 1;
    v = (int'(d) - 5) * 450 / den + 50;
    if (v < 50) v = 50;
    if (v > 500) v = 500;
    return v;
  endfunction

  function automatic int front_duty(logic [7:0] d);
    int den, v;
    den = (p_front_far > 14) ? int'(p_front_far) - 14 : 1;
    v = (int'(d) - 14) * (-200) / den + 300;
    if (v < 100) v = 100;
    if (v > 300) v = 300;
    return v;
  endfunction

  function automatic void tone(inout alert_t r, input int hz, input int on, input int off);
    r.hz = hz[11:0];
    r.on_ms = on[9:0];
    r.off_ms = off[9:0];
  endfunction

  function automatic void right_tone(inout alert_t r, input int hz, input logic [7:0] d);
    int dur;
    dur = side_dur(d);
    tone(r, hz, dur * 2, dur / 2);
  endfunction

  function automatic void left_tone(inout alert_t r, input int hz, input logic [7:0] d);
    int dur;
    dur = side_dur(d);
    tone(r, hz, dur / 2, dur * 2);
  endfunction

  function automatic void pair_tone(inout alert_t r, input reading_t x,
                                    input int alarm, input int rhz, input int lhz);
    if (x.dr < p_side_close && x.dl < p_side_close) tone(r, alarm, 100, 0);
    else if (x.dr < x.dl) right_tone(r, rhz, x.dr);
    else left_tone(r, lhz, x.dl);
  endfunction

  function automatic void say(inout alert_t r, input logic [2:0] c, input int hold,
                              input logic [31:0] now);
    logic [31:0] gap;
    gap = now - p_last_cue_time;
    r.cue = c;
    r.play = (gap > 32'(hold)) || (c != p_last_cue);
    p_last_cue_time = now;
    p_last_cue = c;
  endfunction

  function automatic alert_t predict_alert(reading_t x);
    alert_t r;
    logic both;
    logic [31:0] gap;
    r = '0;
    both = (x.dr < p_side_close) && (x.dl < p_side_close);
    if (x.dl == p_side_far || x.df == p_front_far || x.dr == p_side_far) begin
      r.zone = ZoneNoMatch;
      return r;
    end
    r.zone = {1'b0, x.dl < p_side_far, x.df < p_front_far, x.dr < p_side_far};
    case (r.zone)
      4'd0: begin
        if (x.hp) say(r, CueAhead, 5000, x.now);
      end
      4'd1: begin
        if (!x.hp) right_tone(r, 528, x.dr);
        else if (x.dr > p_side_mid) say(r, CueAhead, 5000, x.now);
        else say(r, CueRightBlk, 1500, x.now);
      end
      4'd2: begin
        r.duty = 9'(front_duty(x.df));
        if (!x.hp) begin
          gap = x.now - p_last_beep;
          if (gap > 32'd1500) begin
            tone(r, 1320, 100, 0);
            p_last_beep = x.now;
          end
        end else say(r, CueStop, 1500, x.now);
      end
      4'd3: begin
        r.duty = 9'(front_duty(x.df));
        if (!x.hp) right_tone(r, 792, x.dr);
        else if (x.dr > p_side_mid) say(r, CueRightBlk, 1500, x.now);
        else say(r, CueGoLeft, 1500, x.now);
      end
      4'd4: begin
        if (!x.hp) left_tone(r, 1320, x.dl);
        else if (x.dl > p_side_mid) say(r, CueAhead, 5000, x.now);
        else say(r, CueLeftBlk, 1500, x.now);
      end
      4'd5: begin
        if (!x.hp) pair_tone(r, x, 1848, 528, 1320);
        else begin
          if (both) tone(r, 1848, 100, 0);
          if (x.dr > p_side_mid && x.dl > p_side_mid) say(r, CueAhead, 5000, x.now);
          else if (x.dr > p_side_close) say(r, CueLeftBlk, 1500, x.now);
          else if (x.dl > p_side_close) say(r, CueRightBlk, 1500, x.now);
          else say(r, CueStop, 1000, x.now);
        end
      end
      4'd6: begin
        r.duty = 9'(front_duty(x.df));
        if (!x.hp) left_tone(r, 1584, x.dl);
        else if (x.dl > p_side_mid) say(r, CueLeftBlk, 1500, x.now);
        else say(r, CueGoRight, 1500, x.now);
      end
      default: begin
        r.duty = 9'd500;
        if (!x.hp || both) begin
          r.duty = 9'(front_duty(x.df));
          pair_tone(r, x, 2112, 792, 1584);
        end
        if (x.hp) say(r, CueStop, 1000, x.now);
      end
    endcase
    return r;
  endfunction

  task automatic wait_quiet();
    while (alert_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // hold cfg_valid across back-to-back writes; set_regs drops it
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegSideFar:   p_side_far = val;
      RegFrontFar:  p_front_far = val;
      RegSideMid:   p_side_mid = val;
      default:      p_side_close = val;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(logic [7:0] sf, logic [7:0] ff, logic [7:0] sm, logic [7:0] sc);
    wait_quiet();
    write_reg(RegSideFar, sf);
    write_reg(RegFrontFar, ff);
    write_reg(RegSideMid, sm);
    write_reg(RegSideClose, sc);
    cfg_valid <= 1'b0;
  endtask

  // drive one reading; valid stays high across back-to-back transfers
  task automatic send(reading_t x, logic known, alert_t res);
    alert_t p;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_dist_left, in_dist_front, in_dist_right, in_headphone_in, in_now_ms} <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_alert(x);
    if (known && p != res) begin
      $error("table row disagrees with prediction: exp %h got %h", res, p);
      fails++;
    end
    alert_q.push_back(p);
    @(negedge clk);
  endtask

  function automatic reading_t rand_reading(logic [31:0] now);
    reading_t x;
    x.hp = 1'($urandom_range(0, 1));
    x.now = now;
    x.dl = ($urandom_range(0, 7) == 0) ? p_side_far : 8'($urandom);
    x.df = ($urandom_range(0, 7) == 0) ? p_front_far : 8'($urandom);
    x.dr = ($urandom_range(0, 7) == 0) ? p_side_far : 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      x.dl = 8'($urandom_range(0, 40));
      x.dr = 8'($urandom_range(0, 40));
    end
    return x;
  endfunction

  // receiver
  always @(negedge clk) begin
    if (hold_long) out_ready <= 1'b0;
    else if (!calm && $urandom_range(0, 4) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    alert_t got, exp_a;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_zone, out_motor_duty, out_tone_hz, out_tone_on_ms, out_tone_off_ms,
              out_cue, out_cue_play};
      if (alert_q.size() == 0) begin
        $error("unexpected result transfer");
        fails++;
      end else begin
        exp_a = alert_q.pop_front();
        if (got.zone != exp_a.zone) begin
          $error("zone exp %0d got %0d", exp_a.zone, got.zone); fails++;
        end
        if (got.duty != exp_a.duty) begin
          $error("motor_duty exp %0d got %0d", exp_a.duty, got.duty); fails++;
        end
        if (got.hz != exp_a.hz) begin
          $error("tone_hz exp %0d got %0d", exp_a.hz, got.hz); fails++;
        end
        if (got.on_ms != exp_a.on_ms) begin
          $error("tone_on_ms exp %0d got %0d", exp_a.on_ms, got.on_ms); fails++;
        end
        if (got.off_ms != exp_a.off_ms) begin
          $error("tone_off_ms exp %0d got %0d", exp_a.off_ms, got.off_ms); fails++;
        end
        if (got.cue != exp_a.cue) begin
          $error("cue exp %0d got %0d", exp_a.cue, got.cue); fails++;
        end
        if (got.play != exp_a.play) begin
          $error("cue_play exp %0d got %0d", exp_a.play, got.play); fails++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk(logic [7:0] dl, logic [7:0] df, logic [7:0] dr, logic hp,
                              logic [31:0] now, logic known, alert_t res);
    row_t r;
    r.rd = '{dl, df, dr, hp, now};
    r.known = known;
    r.res = res;
    return r;
  endfunction

  initial begin
    logic [31:0] now;
    reading_t x;
    int n;
    p_side_far = SideFarRst; p_front_far = FrontFarRst;
    p_side_mid = SideMidRst; p_side_close = SideCloseRst;
    p_last_beep = '0; p_last_cue_time = '0; p_last_cue = CueNone;

    dir_rows.push_back(mk(8'd100, 8'd0, 8'd0, 1'b1, 32'd10, 1'b1, '{ZoneNoMatch, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(8'd0, 8'd100, 8'd0, 1'b0, 32'd10, 1'b1, '{ZoneNoMatch, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(8'd0, 8'd0, 8'd100, 1'b0, 32'd10, 1'b1, '{ZoneNoMatch, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(8'd255, 8'd255, 8'd255, 1'b0, 32'd20, 1'b1, '{4'd0, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(8'd255, 8'd255, 8'd255, 1'b1, 32'd30, 1'b1,
                          '{4'd0, 0,0,0,0, CueAhead, 1'b1}));
    dir_rows.push_back(mk(8'd255, 8'd255, 8'd255, 1'b1, 32'd40, 1'b1,
                          '{4'd0, 0,0,0,0, CueAhead, 1'b0}));
    dir_rows.push_back(mk(8'd255, 8'd255, 8'd255, 1'b1, 32'd6000, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd0, 8'd255, 1'b0, 32'd100, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd99, 8'd255, 1'b0, 32'd2000, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd50, 8'd255, 1'b0, 32'd2100, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd50, 8'd255, 1'b1, 32'd2200, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd255, 8'd0, 1'b0, 32'd1, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd255, 8'd99, 1'b1, 32'd2, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd255, 8'd10, 1'b1, 32'd3, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd20, 8'd70, 1'b1, 32'd4, 1'b0, '0));
    dir_rows.push_back(mk(8'd255, 8'd20, 8'd7, 1'b0, 32'd5, 1'b0, '0));
    dir_rows.push_back(mk(8'd5, 8'd255, 8'd255, 1'b0, 32'd6, 1'b0, '0));
    dir_rows.push_back(mk(8'd80, 8'd255, 8'd255, 1'b1, 32'd7, 1'b0, '0));
    dir_rows.push_back(mk(8'd10, 8'd255, 8'd20, 1'b0, 32'd8, 1'b0, '0));
    dir_rows.push_back(mk(8'd10, 8'd255, 8'd20, 1'b1, 32'd9, 1'b0, '0));
    dir_rows.push_back(mk(8'd90, 8'd255, 8'd70, 1'b1, 32'd10, 1'b0, '0));
    dir_rows.push_back(mk(8'd40, 8'd14, 8'd255, 1'b1, 32'd11, 1'b0, '0));
    dir_rows.push_back(mk(8'd10, 8'd0, 8'd20, 1'b1, 32'd12, 1'b0, '0));
    dir_rows.push_back(mk(8'd50, 8'd60, 8'd40, 1'b0, 32'hFFFF_FFFF, 1'b0, '0));
    dir_rows.push_back(mk(8'd70, 8'd60, 8'd80, 1'b1, 32'hFFFF_FFFF, 1'b0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send(dir_rows[i].rd, dir_rows[i].known, dir_rows[i].res);

    // long receiver stall while readings keep coming
    in_valid <= 1'b0;
    wait_quiet();
    hold_long = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
      end
      for (int k = 0; k < 4; k++) send(rand_reading($urandom), 1'b0, '0);
    join
    in_valid <= 1'b0;

    now = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      in_valid <= 1'b0;
      case (ph)
        0: set_regs(8'd6, 8'd15, 8'd0, 8'd0);
        1: set_regs(8'd255, 8'd255, 8'd255, 8'd255);
        2: set_regs(8'd0, 8'd0, 8'd128, 8'd200);
        3: set_regs(8'd3, 8'd10, 8'd2, 8'd1);
        4: set_regs(8'($urandom_range(6, 255)), 8'($urandom_range(15, 255)),
                    8'($urandom), 8'($urandom));
        5: set_regs(8'd40, 8'd60, 8'd20, 8'd35);
        default: set_regs(SideFarRst, FrontFarRst, SideMidRst, SideCloseRst);
      endcase
      calm = (ph == 7);
      for (n = 0; n < 200; n++) begin
        now = now + $urandom_range(0, 3) * $urandom_range(0, 2600);
        if ($urandom_range(0, 15) == 0) now = $urandom;
        x = rand_reading(now);
        send(x, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_quiet();
    if (fails == 0 && alert_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
